// File: rtl/core/prefix_code_tree_decoder_defines.svh
// Assertion macros used by the checker file of the code tree decoder.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef PREFIX_CODE_TREE_DECODER_DEFINES_SVH
`define PREFIX_CODE_TREE_DECODER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PCTD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pctd assertion failed");

// Next-cycle implication, disabled during reset.
`define PCTD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pctd assertion failed");

`endif

// File: rtl/core/pctd_pkg.sv
// Shared field widths, function codes and status codes of the code tree decoder.
// No dependencies.
`timescale 1ns / 1ps

package pctd_pkg;

    localparam int FUNC_W = 2;
    localparam int SYM_W  = 8;
    localparam int CODE_W = 10;
    localparam int LEN_W  = 4;
    localparam int STAT_W = 2;

    typedef logic [FUNC_W-1:0] func_t;
    typedef logic [SYM_W-1:0]  sym_t;
    typedef logic [STAT_W-1:0] status_t;

    localparam func_t FUNC_LOAD   = 2'd0;
    localparam func_t FUNC_DECODE = 2'd1;
    localparam func_t FUNC_CLEAR  = 2'd2;

    localparam status_t STATUS_OK      = 2'd0;
    localparam status_t STATUS_MISSING = 2'd1;
    localparam status_t STATUS_FULL    = 2'd2;

endpackage

// File: rtl/core/pctd_node_ram.sv
// Node table memory of the code tree decoder: one write port, one read port,
// registered read data. No dependencies.
`timescale 1ns / 1ps

module pctd_node_ram #(
    parameter int DEPTH = 512,
    parameter int AW    = 9,
    parameter int DW    = 27
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/prefix_code_tree_decoder.sv
// Top level of the prefix code tree decoder: sequencer, root registers, result register.
// Depends on pctd_pkg and pctd_node_ram.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel s_*: one transaction is a function code plus its operands.
//     load   - insert symbol s_symbol_in under the s_code_len-bit codeword s_code_bits
//     decode - step the tree walk by s_code_bit, emit a symbol on reaching a leaf
//     clear  - empty the tree and return the walk to the root
//   Result channel m_*: m_symbol_out and m_status; a decode yields a result on a leaf
//   (status ok) or a missing branch, a load yields one only when the node table is full.
// Timing:
//   s_ready is high only while the sequencer is idle. Clear, an empty load and the
//   unused code finish without leaving the idle state. A load steps once per code
//   bit and then writes the leaf; one that runs out of nodes ends at the failing step
//   and emits through the emit state. A decode takes the child from the root registers
//   or after a read of the current node, then emits on a leaf; a missing branch emits
//   in place of the child read. A step that reaches an existing node waits on its read.
// Reset and stall:
//   Reset empties the tree (root and free pointer live in flip-flops, no clearing pass)
//   and drops any pending result. A stalled result holds in the output register; a
//   following item is accepted, and the sequencer waits before emitting a new result.
//
module prefix_code_tree_decoder #(
    parameter int MAX_CODE_LEN = 10,
    parameter int NODE_COUNT   = 512
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [pctd_pkg::FUNC_W-1:0] s_func,
    input  logic [pctd_pkg::SYM_W-1:0]  s_symbol_in,
    input  logic [pctd_pkg::CODE_W-1:0] s_code_bits,
    input  logic [pctd_pkg::LEN_W-1:0]  s_code_len,
    input  logic                      s_code_bit,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [pctd_pkg::SYM_W-1:0]  m_symbol_out,
    output logic [pctd_pkg::STAT_W-1:0] m_status
);

    localparam int IW = $clog2(NODE_COUNT);
    localparam int FW = $clog2(NODE_COUNT + 1);
    localparam int LW = $clog2(MAX_CODE_LEN + 1);
    localparam int XW = (MAX_CODE_LEN > pctd_pkg::CODE_W) ? MAX_CODE_LEN : pctd_pkg::CODE_W;

    typedef struct packed {
        logic [IW-1:0]      c0;
        logic [IW-1:0]      c1;
        logic               leaf;
        pctd_pkg::sym_t     sym;
    } node_t;

    localparam int DW = $bits(node_t);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_DRD   = 3'd2;
    localparam logic [2:0] ST_DNXT  = 3'd3;
    localparam logic [2:0] ST_DLEAF = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]              state_reg, state_next;
    logic [IW-1:0]           root_c0_reg, root_c0_next;
    logic [IW-1:0]           root_c1_reg, root_c1_next;
    logic [FW-1:0]           free_reg, free_next;
    logic [IW-1:0]           cur_reg, cur_next;
    logic [IW-1:0]           node_reg, node_next;
    logic [IW-1:0]           nxt_reg, nxt_next;
    node_t                   ent_reg, ent_next;
    logic                    fresh_reg, fresh_next;
    logic [MAX_CODE_LEN-1:0] word_reg, word_next;
    logic [LW-1:0]           rem_reg, rem_next;
    pctd_pkg::sym_t          sym_reg, sym_next;
    logic                    bit_reg, bit_next;
    pctd_pkg::sym_t          res_sym_reg, res_sym_next;
    pctd_pkg::status_t       res_status_reg, res_status_next;
    logic                    m_valid_reg, m_valid_next;
    pctd_pkg::sym_t          m_symbol_reg, m_symbol_next;
    pctd_pkg::status_t       m_status_reg, m_status_next;

    logic                    mem_we;
    logic [IW-1:0]           mem_waddr;
    logic [DW-1:0]           mem_wdata;
    logic                    mem_re;
    logic [IW-1:0]           mem_raddr;
    logic [DW-1:0]           mem_rdata;

    node_t                   rd_ent;
    node_t                   ent_cur;
    node_t                   ent_upd;
    node_t                   wb_ent;
    logic                    wb_en;
    logic                    ld_bit;
    logic [IW-1:0]           ld_slot;
    logic [IW-1:0]           dec_nxt;
    logic [LW-1:0]           len_sat;
    logic [LW-1:0]           shamt;
    logic [XW-1:0]           code_ext;
    logic [XW-1:0]           code_aligned;
    logic                    out_free;

    pctd_node_ram #(
        .DEPTH (NODE_COUNT),
        .AW    (IW),
        .DW    (DW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign rd_ent   = node_t'(mem_rdata);
    assign ent_cur  = fresh_reg ? rd_ent : ent_reg;
    assign ld_bit   = word_reg[MAX_CODE_LEN-1];
    assign ld_slot  = ld_bit ? ent_cur.c1 : ent_cur.c0;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        ent_upd = ent_cur;
        if (ld_bit) begin
            ent_upd.c1 = free_reg[IW-1:0];
        end else begin
            ent_upd.c0 = free_reg[IW-1:0];
        end
    end

    always_comb begin
        if (state_reg == ST_DRD) begin
            dec_nxt = bit_reg ? root_c1_reg : root_c0_reg;
        end else begin
            dec_nxt = bit_reg ? rd_ent.c1 : rd_ent.c0;
        end
    end

    always_comb begin
        if (int'(s_code_len) > MAX_CODE_LEN) begin
            len_sat = LW'(MAX_CODE_LEN);
        end else begin
            len_sat = LW'(s_code_len);
        end
        shamt        = LW'(MAX_CODE_LEN) - len_sat;
        code_ext     = XW'(s_code_bits);
        code_aligned = code_ext << shamt;
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_symbol_out = m_symbol_reg;
    assign m_status     = m_status_reg;

    always_comb begin
        state_next      = state_reg;
        root_c0_next    = root_c0_reg;
        root_c1_next    = root_c1_reg;
        free_next       = free_reg;
        cur_next        = cur_reg;
        node_next       = node_reg;
        nxt_next        = nxt_reg;
        ent_next        = ent_reg;
        fresh_next      = fresh_reg;
        word_next       = word_reg;
        rem_next        = rem_reg;
        sym_next        = sym_reg;
        bit_next        = bit_reg;
        res_sym_next    = res_sym_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg;
        m_symbol_next   = m_symbol_reg;
        m_status_next   = m_status_reg;
        mem_re          = 1'b0;
        mem_raddr       = cur_reg;
        wb_en           = 1'b0;
        wb_ent          = ent_cur;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg) inside
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_func)
                        pctd_pkg::FUNC_LOAD: begin
                            if (s_code_len != '0) begin
                                sym_next   = s_symbol_in;
                                word_next  = code_aligned[MAX_CODE_LEN-1:0];
                                rem_next   = len_sat;
                                node_next  = '0;
                                ent_next   = '{c0: root_c0_reg, c1: root_c1_reg,
                                               leaf: 1'b0, sym: '0};
                                fresh_next = 1'b0;
                                state_next = ST_LOAD;
                            end
                        end
                        pctd_pkg::FUNC_DECODE: begin
                            bit_next   = s_code_bit;
                            state_next = ST_DRD;
                        end
                        pctd_pkg::FUNC_CLEAR: begin
                            root_c0_next = '0;
                            root_c1_next = '0;
                            free_next    = FW'(1);
                            cur_next     = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_LOAD: begin
                if (rem_reg == '0) begin
                    wb_en       = 1'b1;
                    wb_ent.leaf = 1'b1;
                    wb_ent.sym  = sym_reg;
                    fresh_next  = 1'b0;
                    state_next  = ST_IDLE;
                end else if (ld_slot != '0) begin
                    mem_re     = 1'b1;
                    mem_raddr  = ld_slot;
                    node_next  = ld_slot;
                    fresh_next = 1'b1;
                    word_next  = word_reg << 1;
                    rem_next   = rem_reg - LW'(1);
                end else if (free_reg >= FW'(NODE_COUNT)) begin
                    wb_en           = 1'b1;
                    fresh_next      = 1'b0;
                    res_sym_next    = '0;
                    res_status_next = pctd_pkg::STATUS_FULL;
                    state_next      = ST_EMIT;
                end else begin
                    wb_en      = 1'b1;
                    wb_ent     = ent_upd;
                    node_next  = free_reg[IW-1:0];
                    ent_next   = '0;
                    fresh_next = 1'b0;
                    free_next  = free_reg + FW'(1);
                    word_next  = word_reg << 1;
                    rem_next   = rem_reg - LW'(1);
                end
            end
            ST_DRD, ST_DNXT: begin
                if (state_reg == ST_DRD && cur_reg != '0) begin
                    mem_re     = 1'b1;
                    mem_raddr  = cur_reg;
                    state_next = ST_DNXT;
                end else if (dec_nxt == '0) begin
                    cur_next        = '0;
                    res_sym_next    = '0;
                    res_status_next = pctd_pkg::STATUS_MISSING;
                    state_next      = ST_EMIT;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = dec_nxt;
                    nxt_next   = dec_nxt;
                    state_next = ST_DLEAF;
                end
            end
            ST_DLEAF: begin
                if (rd_ent.leaf) begin
                    cur_next        = '0;
                    res_sym_next    = rd_ent.sym;
                    res_status_next = pctd_pkg::STATUS_OK;
                    state_next      = ST_EMIT;
                end else begin
                    cur_next   = nxt_reg;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_symbol_next = res_sym_reg;
                    m_status_next = res_status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        mem_we    = 1'b0;
        mem_waddr = node_reg;
        mem_wdata = wb_ent;
        if (wb_en) begin
            if (node_reg == '0) begin
                root_c0_next = wb_ent.c0;
                root_c1_next = wb_ent.c1;
            end else begin
                mem_we = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            root_c0_reg <= '0;
            root_c1_reg <= '0;
            free_reg    <= FW'(1);
            cur_reg     <= '0;
            fresh_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            root_c0_reg <= root_c0_next;
            root_c1_reg <= root_c1_next;
            free_reg    <= free_next;
            cur_reg     <= cur_next;
            fresh_reg   <= fresh_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        node_reg       <= node_next;
        nxt_reg        <= nxt_next;
        ent_reg        <= ent_next;
        word_reg       <= word_next;
        rem_reg        <= rem_next;
        sym_reg        <= sym_next;
        bit_reg        <= bit_next;
        res_sym_reg    <= res_sym_next;
        res_status_reg <= res_status_next;
        m_symbol_reg   <= m_symbol_next;
        m_status_reg   <= m_status_next;
    end

endmodule

// File: rtl/core/pctd_checker.sv
// Port-level checker of the code tree decoder and its bind to the top level.
// Depends on pctd_pkg and prefix_code_tree_decoder_defines.svh.
`timescale 1ns / 1ps
`include "prefix_code_tree_decoder_defines.svh"

module pctd_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic [pctd_pkg::FUNC_W-1:0] s_func,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [pctd_pkg::SYM_W-1:0]  m_symbol_out,
    input logic [pctd_pkg::STAT_W-1:0] m_status
);

    logic                                      result_stalled;
    logic                                      result_error;
    logic                                      status_known;
    logic                                      decode_taken;
    logic [pctd_pkg::SYM_W+pctd_pkg::STAT_W-1:0] result_payload;

    assign result_stalled = m_valid && !m_ready;
    assign result_error   = m_valid && (m_status != pctd_pkg::STATUS_OK);
    assign status_known   = (m_status == pctd_pkg::STATUS_OK) ||
                            (m_status == pctd_pkg::STATUS_MISSING) ||
                            (m_status == pctd_pkg::STATUS_FULL);
    assign decode_taken   = s_valid && s_ready && (s_func == pctd_pkg::FUNC_DECODE);
    assign result_payload = {m_symbol_out, m_status};

    `PCTD_ASSERT_NEXT(a_result_hold, result_stalled, m_valid && $stable(result_payload))
    `PCTD_ASSERT_NOW(a_error_symbol_zero, result_error, m_symbol_out == '0)
    `PCTD_ASSERT_NOW(a_status_code, m_valid, status_known)
    `PCTD_ASSERT_NEXT(a_decode_busy, decode_taken, !s_ready)

endmodule

bind prefix_code_tree_decoder pctd_checker u_pctd_checker (.*);
